// ===== hw/rtl/ibmw_pkg.sv =====
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared types, codes and helpers for the indirect block map walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

  // Inode block map layout.
  localparam int unsigned DIRECT_SLOTS = 12;
  localparam int unsigned SLOT_COUNT   = DIRECT_SLOTS + 3;
  localparam logic [3:0]  SLOT_SINGLE  = 4'(DIRECT_SLOTS);
  localparam logic [3:0]  SLOT_DOUBLE  = 4'(DIRECT_SLOTS + 1);
  localparam logic [3:0]  SLOT_TRIPLE  = 4'(DIRECT_SLOTS + 2);

  // Block size register limits and reset value.
  localparam logic [4:0] BSIZE_LOG2_MIN   = 5'd10;
  localparam logic [4:0] BSIZE_LOG2_MAX   = 5'd16;
  localparam logic [4:0] BSIZE_LOG2_RESET = 5'd10;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned INDEX_W  = 14;
  localparam int unsigned OFFSET_W = 2 * INDEX_W;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_START    = 2'd1,
    MODE_RESPONSE = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  // Classified command as handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_LOAD,
    CMD_DIRECT,
    CMD_WALK,
    CMD_RANGE_ERR,
    CMD_RESPONSE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e               op;
    logic [3:0]            slot;    // table slot to write or read
    logic [WORD_W-1:0]     word;    // load value or response word
    logic [INDEX_W-1:0]    index;   // first pointer word index of a walk
    logic [1:0]            levels;  // reads still to come after the first
    logic [OFFSET_W-1:0]   offset;  // offset within the deeper levels
  } cmd_t;

  // Pointers per block as a shift amount, with the block size clamped.
  function automatic logic [3:0] ptr_log2(input logic [4:0] bsize_log2);
    logic [4:0] b;
    b = bsize_log2;
    if (b < BSIZE_LOG2_MIN) begin
      b = BSIZE_LOG2_MIN;
    end
    if (b > BSIZE_LOG2_MAX) begin
      b = BSIZE_LOG2_MAX;
    end
    return 4'(b - 5'd2);
  endfunction

endpackage

// ===== hw/rtl/indirect_block_map_walker.sv =====
// ----------------------------------------------------------------------------
// indirect_block_map_walker
// Translates file logical block numbers through an ext2 inode block map.
// ----------------------------------------------------------------------------
// The block accepts one input transaction per clock cycle while input stall is
// low. The front decodes each transaction and, for a start, picks the direct,
// single, double or triple indirect level or flags a range error; the back owns
// the 15-entry pointer table and the walk state and executes one queued command
// per cycle when its result can be taken. A command enters the queue at the
// accepting edge; the back registers its result from the head of the queue.
// The back drains one command per cycle while the output register can take
// its result; when the output stalls, the command queue (QueueDepth entries)
// fills and input stall rises. Each pointer word request is answered by a
// read response transaction, so the walk's pace follows the memory latency.
// ----------------------------------------------------------------------------
module indirect_block_map_walker #(
  parameter int unsigned QueueDepth = ibmw_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] word_i,
  input  logic [31:0] logical_block_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] block_id_o,
  output logic [13:0] word_index_o
);
  import ibmw_pkg::*;

  logic [4:0] bsize_log2_q;
  logic [3:0] ptr_log2_w;
  logic       cfg_write;
  logic       push;
  cmd_t       push_cmd;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  cmd_t       head_cmd;

  // Block size register, the only register of the port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {27'd0, bsize_log2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_log2_q <= BSIZE_LOG2_RESET;
    end else if (cfg_write) begin
      bsize_log2_q <= pwdata[4:0];
    end
  end

  assign ptr_log2_w = ptr_log2(bsize_log2_q);
  assign in_stall_o = queue_full;

  ibmw_front u_front (
    .in_valid_i      (in_valid_i && !queue_full),
    .mode_i          (mode_i),
    .slot_i          (slot_i),
    .word_i          (word_i),
    .logical_block_i (logical_block_i),
    .ptr_log2_i      (ptr_log2_w),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  ibmw_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  ibmw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ptr_log2_i   (ptr_log2_w),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .block_id_o   (block_id_o),
    .word_index_o (word_index_o)
  );

endmodule

// ===== hw/rtl/ibmw_front.sv =====
// ----------------------------------------------------------------------------
// ibmw_front
// Decodes input transactions and picks the indirection level of a start.
// ----------------------------------------------------------------------------
module ibmw_front (
  input  logic                  in_valid_i,
  input  logic [1:0]            mode_i,
  input  logic [3:0]            slot_i,
  input  logic [31:0]           word_i,
  input  logic [31:0]           logical_block_i,
  input  logic [3:0]            ptr_log2_i,
  output logic                  push_o,
  output ibmw_pkg::cmd_t        cmd_o
);
  import ibmw_pkg::*;

  logic [31:0] lb1;
  logic [31:0] lb2;
  logic [31:0] lb3;
  logic [4:0]  sh2;
  logic [5:0]  sh3;
  logic [31:0] one1;
  logic [31:0] one2;
  logic [31:0] mask1;
  logic [31:0] mask2;
  mode_e       mode;

  assign mode  = mode_e'(mode_i);
  assign sh2   = {ptr_log2_i, 1'b0};
  assign sh3   = 6'(ptr_log2_i) + 6'(sh2);
  assign one1  = 32'd1 << ptr_log2_i;
  assign one2  = 32'd1 << sh2;
  assign mask1 = one1 - 32'd1;
  assign mask2 = one2 - 32'd1;

  // Strip the offsets of the direct, single and double ranges in turn.
  assign lb1 = logical_block_i - 32'(DIRECT_SLOTS);
  assign lb2 = lb1 - one1;
  assign lb3 = lb2 - one2;

  // Classify the transaction into a back-end command.
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = CMD_LOAD;
    cmd_o.slot   = slot_i;
    cmd_o.word   = word_i;
    push_o       = 1'b0;
    case (mode)
      MODE_LOAD: begin
        // Writes beyond the last slot are dropped here.
        push_o = in_valid_i && (slot_i < 4'(SLOT_COUNT));
      end
      MODE_START: begin
        push_o = in_valid_i;
        if (logical_block_i < 32'(DIRECT_SLOTS)) begin
          cmd_o.op   = CMD_DIRECT;
          cmd_o.slot = logical_block_i[3:0];
        end else if ((lb1 >> ptr_log2_i) == 32'd0) begin
          cmd_o.op    = CMD_WALK;
          cmd_o.slot  = SLOT_SINGLE;
          cmd_o.index = lb1[INDEX_W-1:0];
        end else if ((lb2 >> sh2) == 32'd0) begin
          cmd_o.op     = CMD_WALK;
          cmd_o.slot   = SLOT_DOUBLE;
          cmd_o.index  = INDEX_W'(lb2 >> ptr_log2_i);
          cmd_o.levels = 2'd1;
          cmd_o.offset = OFFSET_W'(lb2 & mask1);
        end else if ((lb3 >> sh3) == 32'd0) begin
          cmd_o.op     = CMD_WALK;
          cmd_o.slot   = SLOT_TRIPLE;
          cmd_o.index  = INDEX_W'(lb3 >> sh2);
          cmd_o.levels = 2'd2;
          cmd_o.offset = OFFSET_W'(lb3 & mask2);
        end else begin
          cmd_o.op = CMD_RANGE_ERR;
        end
      end
      MODE_RESPONSE: begin
        // Whether a walk awaits it is known only in the back.
        cmd_o.op = CMD_RESPONSE;
        push_o   = in_valid_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ibmw_queue.sv =====
// ----------------------------------------------------------------------------
// ibmw_queue
// Small command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module ibmw_queue #(
  parameter int unsigned DEPTH = ibmw_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ibmw_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ibmw_pkg::cmd_t  head_o
);
  import ibmw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ibmw_back.sv =====
// ----------------------------------------------------------------------------
// ibmw_back
// Holds the pointer table and walk state and produces result transactions.
// ----------------------------------------------------------------------------
module ibmw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      ptr_log2_i,
  input  logic            head_valid_i,
  input  ibmw_pkg::cmd_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [31:0]     block_id_o,
  output logic [13:0]     word_index_o
);
  import ibmw_pkg::*;

  logic [WORD_W-1:0]   ptr_table_q [SLOT_COUNT];
  logic                busy_q, busy_d;
  logic [1:0]          levels_q, levels_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic                out_valid_q, out_valid_d;
  kind_e               kind_q, kind_d;
  logic [WORD_W-1:0]   block_q, block_d;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic                needs_out;
  logic                out_free;
  logic                do_pop;
  logic [3:0]          shift;
  logic [OFFSET_W-1:0] mask1;
  logic [OFFSET_W-1:0] low_mask;
  logic [WORD_W-1:0]   table_rd;

  assign table_rd = ptr_table_q[head_i.slot];
  assign mask1    = (OFFSET_W'(1) << ptr_log2_i) - OFFSET_W'(1);
  assign shift    = (levels_q == 2'd2) ? ptr_log2_i : 4'd0;
  assign low_mask = (OFFSET_W'(1) << shift) - OFFSET_W'(1);

  // A command that yields a result waits for room in the output register.
  assign needs_out = (head_i.op == CMD_DIRECT) || (head_i.op == CMD_WALK) ||
                     (head_i.op == CMD_RANGE_ERR) ||
                     ((head_i.op == CMD_RESPONSE) && busy_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_pop    = head_valid_i && (!needs_out || out_free);
  assign pop_o     = do_pop;

  // Execute the command at the head of the queue.
  always_comb begin
    busy_d      = busy_q;
    levels_d    = levels_q;
    offset_d    = offset_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    block_d     = block_q;
    index_d     = index_q;
    if (do_pop) begin
      case (head_i.op)
        CMD_DIRECT: begin
          busy_d      = 1'b0;
          levels_d    = 2'd0;
          offset_d    = '0;
          out_valid_d = 1'b1;
          kind_d      = KIND_FINAL;
          block_d     = table_rd;
          index_d     = '0;
        end
        CMD_WALK: begin
          busy_d      = 1'b1;
          levels_d    = head_i.levels;
          offset_d    = head_i.offset;
          out_valid_d = 1'b1;
          kind_d      = KIND_REQ;
          block_d     = table_rd;
          index_d     = head_i.index;
        end
        CMD_RANGE_ERR: begin
          busy_d      = 1'b0;
          levels_d    = 2'd0;
          offset_d    = '0;
          out_valid_d = 1'b1;
          kind_d      = KIND_ERR;
          block_d     = '0;
          index_d     = '0;
        end
        CMD_RESPONSE: begin
          if (busy_q) begin
            out_valid_d = 1'b1;
            block_d     = head_i.word;
            if (levels_q == 2'd0) begin
              // Last level: the returned word is the data block.
              busy_d   = 1'b0;
              offset_d = '0;
              kind_d   = KIND_FINAL;
              index_d  = '0;
            end else begin
              kind_d   = KIND_REQ;
              index_d  = INDEX_W'((offset_q >> shift) & mask1);
              offset_d = offset_q & low_mask;
              levels_d = levels_q - 2'd1;
            end
          end
        end
        default: begin
          // Loads touch only the pointer table.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      levels_q    <= 2'd0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      levels_q    <= levels_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and pointer table writes.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    block_q <= block_d;
    index_q <= index_d;
    if (do_pop && (head_i.op == CMD_LOAD)) begin
      ptr_table_q[head_i.slot] <= head_i.word;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign block_id_o   = block_q;
  assign word_index_o = index_q;

endmodule
